>>> hdl/kreyv_pkg.sv
// ----------------------------------------------------------------------------
// kreyv_pkg
// Shared types and constants for the Kreyvium keystream decryptor.
// ----------------------------------------------------------------------------
package kreyv_pkg;

    localparam int STATE_BITS = 288;
    localparam int RING_BITS  = 128;
    localparam int HALF_BITS  = 64;
    localparam int BYTE_BITS  = 8;

    localparam logic [HALF_BITS-1:0] IV_RESET = 64'h1111_1111_1111_1111;

    // input command codes, carried on s_tuser
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [1:0] REG_KEY_SECOND = 2'd1;
    localparam logic [1:0] REG_IV_FIRST   = 2'd2;
    localparam logic [1:0] REG_IV_SECOND  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WARM,
        ST_DEC,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic load;     // load state and rings from key and IV
        logic round;    // run one cipher round
        logic capture;  // latch input byte and last flag, clear keystream
        logic emit;     // write plaintext beat to the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free; // output register empty or being drained
    } dp_status_t;

endpackage

>>> hdl/kreyv_ctrl.sv
// ----------------------------------------------------------------------------
// kreyv_ctrl
// Sequencer: accepts commands, counts warm-up and keystream rounds,
// and hands the finished byte to the output register.
// ----------------------------------------------------------------------------
module kreyv_ctrl #(
    parameter int WARMUP_ROUNDS = 1152,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    input  kreyv_pkg::dp_status_t status,
    output kreyv_pkg::ctrl_cmd_t  cmd
);
    import kreyv_pkg::*;

    localparam int MAX_ROUNDS = (WARMUP_ROUNDS > BITS_PER_ITEM) ? WARMUP_ROUNDS : BITS_PER_ITEM;
    localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic accept;
    logic warm_done;
    logic dec_done;

    assign accept    = s_tvalid && (state_reg == ST_IDLE);
    assign warm_done = (cnt_reg == CNT_W'(WARMUP_ROUNDS - 1));
    assign dec_done  = (cnt_reg == CNT_W'(BITS_PER_ITEM - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    state_next = (s_tuser == CMD_RESTART) ? ST_WARM : ST_DEC;
                end
            end
            ST_WARM: begin
                cnt_next = cnt_reg + 1'b1;
                if (warm_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEC: begin
                cnt_next = cnt_reg + 1'b1;
                if (dec_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // wait for room in the output register
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load    = accept && (s_tuser == CMD_RESTART);
                cmd.capture = accept && (s_tuser == CMD_DECRYPT);
            end
            ST_WARM: begin
                cmd.round = 1'b1;
            end
            ST_DEC: begin
                cmd.round = 1'b1;
            end
            ST_HOLD: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/kreyv_dp.sv
// ----------------------------------------------------------------------------
// kreyv_dp
// Datapath: key and IV registers, 288-bit cipher state, key and IV rings,
// keystream shifter and the output register.
// ----------------------------------------------------------------------------
module kreyv_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_wdata,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  kreyv_pkg::ctrl_cmd_t  cmd,
    output kreyv_pkg::dp_status_t status
);
    import kreyv_pkg::*;

    logic [HALF_BITS-1:0]  key_first_reg, key_second_reg;
    logic [HALF_BITS-1:0]  iv_first_reg, iv_second_reg;
    logic [STATE_BITS-1:0] st_reg, st_next;
    logic [RING_BITS-1:0]  key_ring_reg, key_ring_next;
    logic [RING_BITS-1:0]  iv_ring_reg, iv_ring_next;
    logic [BYTE_BITS-1:0]  ks_reg, ks_next;
    logic [BYTE_BITS-1:0]  byte_reg;
    logic                  last_reg;
    logic [BYTE_BITS-1:0]  m_data_reg;
    logic                  m_last_reg;
    logic                  m_valid_reg;

    logic [RING_BITS-1:0]  key_vec, iv_vec;
    logic t1, t2, t3, z;
    logic t1n, t2n, t3n;
    logic kb, ivb;

    // vector MSB holds bit 0 of key or IV
    assign key_vec = {key_first_reg, key_second_reg};
    assign iv_vec  = {iv_first_reg, iv_second_reg};
    assign kb      = key_ring_reg[RING_BITS-1];
    assign ivb     = iv_ring_reg[RING_BITS-1];

    always_comb begin
        t1  = st_reg[65] ^ st_reg[92];
        t2  = st_reg[161] ^ st_reg[176];
        t3  = st_reg[242] ^ st_reg[287] ^ kb;
        z   = t1 ^ t2 ^ t3;
        t1n = t1 ^ st_reg[170] ^ ivb ^ (st_reg[90] & st_reg[91]);
        t2n = t2 ^ st_reg[263] ^ (st_reg[174] & st_reg[175]);
        t3n = t3 ^ st_reg[68] ^ (st_reg[285] & st_reg[286]);
    end

    always_comb begin
        st_next       = st_reg;
        key_ring_next = key_ring_reg;
        iv_ring_next  = iv_ring_reg;
        ks_next       = ks_reg;
        if (cmd.load) begin
            for (int i = 0; i < 93; i++) begin
                st_next[i] = key_vec[RING_BITS-1-i];
            end
            for (int i = 0; i < RING_BITS; i++) begin
                st_next[93+i] = iv_vec[RING_BITS-1-i];
            end
            st_next[286:221] = '1;
            st_next[287]     = 1'b0;
            key_ring_next    = key_vec;
            iv_ring_next     = iv_vec;
        end else if (cmd.round) begin
            st_next       = {st_reg[STATE_BITS-2:0], t3n};
            st_next[93]   = t1n;
            st_next[177]  = t2n;
            key_ring_next = {key_ring_reg[RING_BITS-2:0], key_ring_reg[RING_BITS-1]};
            iv_ring_next  = {iv_ring_reg[RING_BITS-2:0], iv_ring_reg[RING_BITS-1]};
            ks_next       = {ks_reg[BYTE_BITS-2:0], z};
        end else if (cmd.capture) begin
            ks_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_first_reg  <= '0;
            key_second_reg <= '0;
            iv_first_reg   <= IV_RESET;
            iv_second_reg  <= IV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_FIRST:  key_first_reg  <= cfg_wdata;
                REG_KEY_SECOND: key_second_reg <= cfg_wdata;
                REG_IV_FIRST:   iv_first_reg   <= cfg_wdata;
                REG_IV_SECOND:  iv_second_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            key_ring_reg <= '0;
            iv_ring_reg  <= '0;
        end else begin
            st_reg       <= st_next;
            key_ring_reg <= key_ring_next;
            iv_ring_reg  <= iv_ring_next;
        end
    end

    always_ff @(posedge aclk) begin
        ks_reg <= ks_next;
        if (cmd.capture) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (cmd.emit) begin
            m_data_reg <= byte_reg ^ ks_reg;
            m_last_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tdata         = m_data_reg;
    assign m_tlast         = m_last_reg;
    assign m_tvalid        = m_valid_reg;

endmodule

>>> hdl/kreyvium_keystream_decrypt.sv
// ----------------------------------------------------------------------------
// kreyvium_keystream_decrypt
// Kreyvium stream cipher on plain bits: restart with key and IV plus warm-up,
// then decrypt one ciphertext byte per command beat.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  s_        in         tdata[7:0] cipher_byte, tuser command, tlast last_in
//  m_        out        tdata[7:0] plain_byte, tlast last_out
//  cfg_      in         cfg_index register, cfg_wdata 64-bit value
//
//  One cipher round runs per cycle through the state register loop.
//  Restart beat: load key and IV on accept, then run the warm-up rounds, no output beat.
//  Decrypt beat: capture the byte on accept, run one keystream round per bit, then load
//  the output register as soon as it has room.
//  s_tready is low while rounds run or a finished byte waits for the output
//  register; a new beat is taken while the previous output beat is still held.
//  Reset (aresetn low, synchronous) clears cipher state and rings, no sweep.
// ----------------------------------------------------------------------------
module kreyvium_keystream_decrypt #(
    parameter int WARMUP_ROUNDS = 1152,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] cipher_byte
    input  logic        s_tuser,    // [0] command
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] plain_byte
    output logic        m_tlast
);
    import kreyv_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    kreyv_ctrl #(
        .WARMUP_ROUNDS(WARMUP_ROUNDS),
        .BITS_PER_ITEM(BITS_PER_ITEM)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .status  (status),
        .cmd     (cmd)
    );

    kreyv_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

`ifndef SYNTHESIS
    // never overwrite a beat that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("output register overwritten");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted beat not shown on output");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new beat taken while rounds pending");

    a_load_round: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && (cmd.round || cmd.capture || cmd.emit)))
        else $error("load overlaps other datapath command");
`endif

endmodule

>>> tb/kreyvium_keystream_decrypt_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kreyvium_keystream_decrypt_tb
// Self-checking bench for the Kreyvium byte decryptor. A bit-level model of
// the cipher predicts every plaintext beat. Restart and decrypt beats are
// driven under several key and IV settings and under varied stalls on both
// sides, including two long output hold-offs.
// ----------------------------------------------------------------------------
module kreyvium_keystream_decrypt_tb;
    import kreyv_pkg::*;

    localparam int WARMUP_ROUNDS = 1152;
    localparam int BITS_PER_ITEM = 8;
    localparam int PHASE_BEATS   = 185;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = WARMUP_ROUNDS + BITS_PER_ITEM + 16;

    typedef struct packed {
        logic [BYTE_BITS-1:0] plain;
        logic                 last;
    } plain_beat_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // Bit-level cipher model plus the queue of plaintext beats still owed.
    class plaintext_scoreboard;
        logic [HALF_BITS-1:0]  key_hi, key_lo, iv_hi, iv_lo;
        logic [STATE_BITS-1:0] cstate;
        logic [RING_BITS-1:0]  key_ring, iv_ring;
        plain_beat_t           owed_q[$];
        int                    warmup;
        int                    errors;

        function new(int warmup_rounds);
            warmup   = warmup_rounds;
            key_hi   = '0;
            key_lo   = '0;
            iv_hi    = IV_RESET;
            iv_lo    = IV_RESET;
            cstate   = '0;
            key_ring = '0;
            iv_ring  = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [HALF_BITS-1:0] val);
            case (idx)
                REG_KEY_FIRST:  key_hi = val;
                REG_KEY_SECOND: key_lo = val;
                REG_IV_FIRST:   iv_hi  = val;
                REG_IV_SECOND:  iv_lo  = val;
                default: ;
            endcase
        endfunction

        // One round; bit i of cstate is cell i, the rings hand out their MSB.
        function logic cipher_round();
            logic kb, ivb, t1, t2, t3, z;
            kb  = key_ring[RING_BITS-1];
            ivb = iv_ring[RING_BITS-1];
            t1  = cstate[65] ^ cstate[92];
            t2  = cstate[161] ^ cstate[176];
            t3  = cstate[242] ^ cstate[287] ^ kb;
            z   = t1 ^ t2 ^ t3;
            t1  = t1 ^ cstate[170] ^ ivb ^ (cstate[90] & cstate[91]);
            t2  = t2 ^ cstate[263] ^ (cstate[174] & cstate[175]);
            t3  = t3 ^ cstate[68] ^ (cstate[285] & cstate[286]);
            cstate      = {cstate[STATE_BITS-2:0], 1'b0};
            cstate[0]   = t3;
            cstate[93]  = t1;
            cstate[177] = t2;
            key_ring = {key_ring[RING_BITS-2:0], key_ring[RING_BITS-1]};
            iv_ring  = {iv_ring[RING_BITS-2:0], iv_ring[RING_BITS-1]};
            return z;
        endfunction

        function void reload();
            logic [RING_BITS-1:0] key, iv;
            key = {key_hi, key_lo};
            iv  = {iv_hi, iv_lo};
            for (int i = 0; i < 93; i++)
                cstate[i] = key[RING_BITS-1-i];
            for (int i = 0; i < RING_BITS; i++)
                cstate[93+i] = iv[RING_BITS-1-i];
            for (int i = 221; i < STATE_BITS-1; i++)
                cstate[i] = 1'b1;
            cstate[STATE_BITS-1] = 1'b0;
            key_ring = key;
            iv_ring  = iv;
            for (int r = 0; r < warmup; r++)
                void'(cipher_round());
        endfunction

        function void note_input(logic cmd, logic [BYTE_BITS-1:0] cbyte, logic last);
            logic [BYTE_BITS-1:0] ks;
            plain_beat_t          beat;
            if (cmd == CMD_RESTART) begin
                reload();
            end else begin
                ks = '0;
                for (int k = 0; k < BITS_PER_ITEM; k++)
                    ks = {ks[BYTE_BITS-2:0], cipher_round()};
                beat.plain = cbyte ^ ks;
                beat.last  = last;
                owed_q.insert(owed_q.size(), beat);
            end
        endfunction

        function void check_result(logic [BYTE_BITS-1:0] plain, logic last);
            plain_beat_t want;
            if (owed_q.size() == 0) begin
                $error("unexpected plaintext beat: plain_byte %02h last_out %0b", plain, last);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (plain !== want.plain) begin
                $error("plain_byte: expected %02h, got %02h", want.plain, plain);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_out: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = REG_KEY_FIRST;
    logic [HALF_BITS-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] cipher_byte
    logic                 s_tuser   = CMD_DECRYPT;   // [0] command
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [7:0] plain_byte
    logic                 m_tlast;

    plaintext_scoreboard sb = new(WARMUP_ROUNDS);

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    kreyvium_keystream_decrypt #(
        .WARMUP_ROUNDS(WARMUP_ROUNDS),
        .BITS_PER_ITEM(BITS_PER_ITEM)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: check each output beat, stall at random or for a long hold.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("kreyvium_keystream_decrypt_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin tx_idle_pct = 67; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
            IDLE_BOTH:     begin tx_idle_pct = 38; rx_stall_pct = 38; end
            default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    task automatic send_beat(input logic cmd, input logic [7:0] cbyte, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= cbyte;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, cbyte, last);
    endtask

    // Drop valid, wait for every owed beat, then let a warm-up run out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [HALF_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [HALF_BITS-1:0] k1, input logic [HALF_BITS-1:0] k2,
                               input logic [HALF_BITS-1:0] v1, input logic [HALF_BITS-1:0] v2);
        write_reg(REG_KEY_FIRST, k1);
        write_reg(REG_KEY_SECOND, k2);
        write_reg(REG_IV_FIRST, v1);
        write_reg(REG_IV_SECOND, v2);
        cfg_we <= 1'b0;
    endtask

    task automatic run_messages(input int n_beats, input logic pressure);
        logic cmd;
        send_beat(CMD_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < n_beats; i++) begin
            if (pressure && i == n_beats / 3)
                hold_req = 1'b1;
            cmd = ($urandom_range(49) == 0) ? CMD_RESTART : CMD_DECRYPT;
            send_beat(cmd, 8'($urandom_range(255)), ($urandom_range(7) == 0));
        end
        drain();
    endtask

    initial begin
        logic [HALF_BITS-1:0] k1, k2, v1, v2;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero state before any restart, default key and IV, then
        // restart edge cases with ignored payload and a restart mid-message.
        set_idle_mode(IDLE_NONE);
        send_beat(CMD_DECRYPT, 8'h00, 1'b0);
        send_beat(CMD_DECRYPT, 8'hFF, 1'b1);
        send_beat(CMD_RESTART, 8'hFF, 1'b1);
        send_beat(CMD_DECRYPT, 8'h00, 1'b0);
        send_beat(CMD_DECRYPT, 8'hFF, 1'b0);
        send_beat(CMD_DECRYPT, 8'hA5, 1'b0);
        send_beat(CMD_DECRYPT, 8'h5A, 1'b1);
        send_beat(CMD_RESTART, 8'h00, 1'b0);
        send_beat(CMD_RESTART, 8'h00, 1'b0);
        send_beat(CMD_DECRYPT, 8'h80, 1'b0);
        send_beat(CMD_DECRYPT, 8'h01, 1'b1);
        send_beat(CMD_DECRYPT, 8'h3C, 1'b0);
        send_beat(CMD_RESTART, 8'h3C, 1'b1);
        send_beat(CMD_DECRYPT, 8'hC3, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            k1 = {$urandom, $urandom};
            k2 = {$urandom, $urandom};
            v1 = {$urandom, $urandom};
            v2 = {$urandom, $urandom};
            case (p)
                0: begin k1 = '0; k2 = '0; v1 = '0; v2 = '0; end
                1: begin k1 = '1; k2 = '1; v1 = '1; v2 = '1; end
                2: begin k1 = '1; k2 = '0; v1 = '0; v2 = '1; end
                7: begin k1 = '0; k2 = '0; v1 = IV_RESET; v2 = IV_RESET; end
                default: ;
            endcase
            load_config(k1, k2, v1, v2);
            set_idle_mode(idle_mode_t'(p % 4));
            run_messages(PHASE_BEATS, (p == 2 || p == 4));
        end

        while (sb.owed_q.size() != 0) begin
            void'(sb.owed_q.pop_front());
            $error("plaintext beat never arrived");
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("kreyvium_keystream_decrypt_tb OK");
        end else begin
            $display("kreyvium_keystream_decrypt_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/kreyv_pkg.sv
hdl/kreyv_ctrl.sv
hdl/kreyv_dp.sv
hdl/kreyvium_keystream_decrypt.sv
tb/kreyvium_keystream_decrypt_tb.sv
